>>> design/ucd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucd_pkg: shared constants for the cycle detector
// sizes of the stores and the action codes of the request stream
// ----------------------------------------------------------------------------
package ucd_pkg;
    localparam int MAX_VERTICES    = 1024;
    localparam int MAX_ADJ_ENTRIES = 8192;
    localparam int VW = $clog2(MAX_VERTICES);        // vertex id width
    localparam int AW = $clog2(MAX_ADJ_ENTRIES);     // adjacency address width
    localparam int CW = VW + 1;                      // vertex count width
    localparam int EW = AW + 1;                      // entry count width

    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_CLOSE  = 2'd1;
    localparam logic [1:0] ACT_RUN    = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;        // ignored, no result
endpackage

>>> design/undirected_cycle_detect_dfs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// undirected_cycle_detect_dfs_core: depth-first cycle detector
// ----------------------------------------------------------------------------
// Requests come in on s_axis: tdata[1:0] action, tdata[11:2] neighbor.
// Append and close requests are taken one per cycle and store the
// adjacency lists of vertices in order. A run request clears all 1024
// visited bits (one a cycle, whatever the vertex count), then walks
// depth-first under a small sequencer through single-port memories for
// adjacency, list ends, visited bits and the walk stack: it tests each root
// candidate, pushes unvisited vertices, examines each stored neighbour and
// pops a vertex when its list is done; s_axis_tready is low meanwhile.
// Then one result goes out on m_axis: tdata[0] cycle_found, tdata[1]
// load_overflow. It waits in the output register while m_axis_tready is
// low; loads for the next graph are still taken, and a following run that
// ends before the result has gone holds, with s_axis_tready low, until it
// has. Reset empties the load state, clears the flags and sets vertex_count
// to 1. vertex_count is written through cfg_wr_en / cfg_wr_data; the user
// must do so only when idle, as the core itself does not enforce this.
// ----------------------------------------------------------------------------
module undirected_cycle_detect_dfs_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [1:0] action, [11:2] neighbor
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] cycle_found, [1] load_overflow
);
    import ucd_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_ROOT  = 4'd2;
    localparam logic [3:0] S_TOP   = 4'd3;
    localparam logic [3:0] S_BEG   = 4'd4;
    localparam logic [3:0] S_END   = 4'd5;
    localparam logic [3:0] S_POS   = 4'd6;
    localparam logic [3:0] S_ADJ   = 4'd7;
    localparam logic [3:0] S_NB    = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_PUSH  = 4'd10;
    localparam logic [3:0] S_PBEG  = 4'd11;
    localparam logic [3:0] S_FETCH = 4'd12;
    localparam logic [3:0] S_CHK   = 4'd13;

    localparam int SW = VW + VW + 1 + EW;           // stack entry width

    logic [CW-1:0] vcount_reg;
    logic [EW-1:0] entry_count_reg;
    logic [CW-1:0] lists_closed_reg;
    logic          overflow_reg, cycle_reg;
    logic [3:0]    state_reg;
    logic [CW-1:0] idx_reg;      // clear index / root
    logic [CW-1:0] sp_reg;
    logic [VW-1:0] v_reg, par_reg, w_reg;
    logic          hp_reg;
    logic [EW-1:0] pos_reg, end_reg;
    logic          res_valid_reg, res_cyc_reg, res_ovf_reg;

    // memories
    logic [VW-1:0] adj_mem [MAX_ADJ_ENTRIES];
    logic [EW-1:0] lend_mem [MAX_VERTICES];
    logic [SW-1:0] stk_mem [MAX_VERTICES];
    logic          vis_mem [MAX_VERTICES];
    logic [VW-1:0] adj_rd;
    logic [EW-1:0] lend_rd;
    logic [SW-1:0] stk_rd;
    logic          vis_rd;

    logic [1:0]    act;
    logic [VW-1:0] nb;
    logic [CW-1:0] neff;
    logic [CW-1:0] sp_dec;
    logic          acc;
    assign act  = s_axis_tdata[1:0];
    assign nb   = s_axis_tdata[VW+1:2];
    assign neff = (vcount_reg > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : vcount_reg;
    assign sp_dec = sp_reg - 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign acc = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata  = {6'd0, res_ovf_reg, res_cyc_reg};

    // memory address, write enable and write data selection
    logic          adj_we, lend_we, stk_we, vis_we, vis_wd;
    logic [AW-1:0] adj_addr;
    logic [VW-1:0] lend_addr, stk_addr, vis_addr;
    logic [SW-1:0] stk_wd;
    logic [EW-1:0] lend_wd;

    always_comb
    begin
        adj_we    = acc && act == ACT_APPEND && lists_closed_reg < CW'(MAX_VERTICES)
                    && entry_count_reg < EW'(MAX_ADJ_ENTRIES) && {1'b0, nb} < neff;
        adj_addr  = (state_reg == S_IDLE) ? entry_count_reg[AW-1:0] : pos_reg[AW-1:0];
        lend_we   = acc && act == ACT_CLOSE && lists_closed_reg < CW'(MAX_VERTICES);
        lend_wd   = entry_count_reg;
        lend_addr = lists_closed_reg[VW-1:0];
        if (state_reg == S_PUSH)
            lend_addr = v_reg - 1'b1;
        else if (state_reg == S_END)
            lend_addr = stk_rd[SW-1 -: VW];
        stk_addr  = (state_reg == S_PBEG) ? sp_reg[VW-1:0] : sp_dec[VW-1:0];
        stk_we    = (state_reg == S_PBEG) || (state_reg == S_ADJ);
        stk_wd    = {v_reg, par_reg, hp_reg, pos_reg};
        if (state_reg == S_ADJ)
            stk_wd = {v_reg, par_reg, hp_reg, pos_reg + 1'b1};
        vis_we    = (state_reg == S_CLR) || (state_reg == S_PBEG);
        vis_wd    = (state_reg == S_PBEG);
        vis_addr  = (state_reg == S_PBEG) ? v_reg : idx_reg[VW-1:0];
        if (state_reg == S_FETCH)
            vis_addr = adj_rd;
    end

    always_ff @(posedge clk)
    begin
        if (adj_we)
            adj_mem[adj_addr] <= nb;
        adj_rd <= adj_mem[adj_addr];
        if (lend_we)
            lend_mem[lend_addr] <= lend_wd;
        lend_rd <= lend_mem[lend_addr];
        if (stk_we)
            stk_mem[stk_addr] <= stk_wd;
        stk_rd <= stk_mem[stk_addr];
        if (vis_we)
            vis_mem[vis_addr] <= vis_wd;
        vis_rd <= vis_mem[vis_addr];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg       <= CW'(1);
            entry_count_reg  <= '0;
            lists_closed_reg <= '0;
            overflow_reg     <= 1'b0;
            cycle_reg        <= 1'b0;
            state_reg        <= S_IDLE;
            idx_reg          <= '0;
            sp_reg           <= '0;
            res_valid_reg    <= 1'b0;
            v_reg <= '0; par_reg <= '0; w_reg <= '0; hp_reg <= 1'b0;
            pos_reg <= '0; end_reg <= '0; res_cyc_reg <= 1'b0; res_ovf_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                vcount_reg <= cfg_wr_data;
            if (res_valid_reg && m_axis_tready && state_reg != S_OUT)
                res_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (acc)
                    begin
                        if (act == ACT_APPEND)
                        begin
                            if (adj_we)
                                entry_count_reg <= entry_count_reg + 1'b1;
                            else
                                overflow_reg <= 1'b1;
                        end
                        else if (act == ACT_CLOSE)
                        begin
                            if (lend_we)
                                lists_closed_reg <= lists_closed_reg + 1'b1;
                            else
                                overflow_reg <= 1'b1;
                        end
                        else if (act == ACT_RUN)
                        begin
                            idx_reg   <= '0;
                            cycle_reg <= 1'b0;
                            sp_reg    <= '0;
                            state_reg <= S_CLR;
                        end
                    end
                end
                S_CLR:
                begin
                    // clear visited bits one vertex a cycle
                    if (idx_reg == CW'(MAX_VERTICES - 1))
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_ROOT;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_ROOT:
                begin
                    // visited read of idx_reg issues here; vis_rd holds it in S_POS
                    if (idx_reg >= neff)
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_POS;
                    v_reg <= idx_reg[VW-1:0];
                end
                S_POS:
                begin
                    if (vis_rd)
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_ROOT;
                        end
                    else
                    begin
                        par_reg   <= '0;
                        hp_reg    <= 1'b0;
                        state_reg <= S_PUSH;
                    end
                end
                S_PUSH:
                begin
                    // start position of v_reg's list
                    if ({1'b0, v_reg} < lists_closed_reg && v_reg != '0)
                        state_reg <= S_BEG;
                    else
                    begin
                        pos_reg   <= '0;
                        state_reg <= S_PBEG;
                    end
                end
                S_BEG:
                begin
                    // end of the previous list, read issued in S_PUSH
                    pos_reg   <= lend_rd;
                    state_reg <= S_PBEG;
                end
                S_PBEG:
                begin
                    // stack write and visited mark
                    if (sp_reg < CW'(MAX_VERTICES))
                        sp_reg <= sp_reg + 1'b1;
                    state_reg <= S_TOP;
                end
                S_TOP:
                begin
                    if (sp_reg == '0)
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_ROOT;
                    end
                    else
                        state_reg <= S_END;
                end
                S_END:
                begin
                    // stack entry now in stk_rd; fetch list end of its vertex
                    {v_reg, par_reg, hp_reg, pos_reg} <= stk_rd;
                    state_reg <= S_NB;
                    end_reg   <= '0;
                end
                S_NB:
                begin
                    // list end of the top vertex, read issued in S_END
                    end_reg   <= ({1'b0, v_reg} < lists_closed_reg) ? lend_rd : '0;
                    state_reg <= S_ADJ;
                end
                S_ADJ:
                begin
                    if (pos_reg >= end_reg || pos_reg >= EW'(MAX_ADJ_ENTRIES))
                    begin
                        sp_reg    <= sp_reg - 1'b1;
                        state_reg <= S_TOP;
                    end
                    else
                    begin
                        // stack pos incremented by the write this cycle
                        state_reg <= S_FETCH;
                    end
                end
                S_FETCH:
                begin
                    // adj_rd valid; visited read of it issues now
                    w_reg     <= adj_rd;
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if ({1'b0, w_reg} >= neff)
                        state_reg <= S_TOP;
                    else if (vis_rd)
                    begin
                        if (!(hp_reg && w_reg == par_reg))
                            cycle_reg <= 1'b1;
                        state_reg <= S_TOP;
                    end
                    else
                    begin
                        par_reg   <= v_reg;
                        hp_reg    <= 1'b1;
                        v_reg     <= w_reg;
                        state_reg <= S_PUSH;
                    end
                end
                S_OUT:
                begin
                    // hold while the previous result still waits
                    if (!res_valid_reg || m_axis_tready)
                    begin
                        res_valid_reg    <= 1'b1;
                        res_cyc_reg      <= cycle_reg;
                        res_ovf_reg      <= overflow_reg;
                        entry_count_reg  <= '0;
                        lists_closed_reg <= '0;
                        overflow_reg     <= 1'b0;
                        state_reg        <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // checks
    assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= CW'(MAX_VERTICES)) else $error("stack pointer past depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |=> res_valid_reg) else $error("result lost");
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("waiting result changed");
endmodule
